### rtl/msc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg - marching squares cell segments shared definitions
// Widths, corner and edge codes and the structs passed between the units.
// ----------------------------------------------------------------------------
package msc_pkg;

	localparam int ROW_W         = 10;
	localparam int SAMPLE_W      = 16;
	localparam int BIAS_W        = 16;
	localparam int SUM_W         = BIAS_W + 1;
	localparam int BASE_W        = ROW_W + 1;
	localparam int COORD_W       = 18;
	localparam int EDGE_W        = 2;
	localparam int GRID_DIM      = 1024;
	localparam int FRAC_BITS_DEF = 8;
	localparam int CQ_DEPTH      = 4;

	localparam logic [COORD_W-1:0] COORD_MAX = '1;

	typedef logic [1:0] corner_t;

	localparam corner_t CORNER_TL = 2'd0;
	localparam corner_t CORNER_TR = 2'd1;
	localparam corner_t CORNER_BR = 2'd2;
	localparam corner_t CORNER_BL = 2'd3;

	localparam logic [EDGE_W-1:0] EDGE_TOP    = 2'd0;
	localparam logic [EDGE_W-1:0] EDGE_RIGHT  = 2'd1;
	localparam logic [EDGE_W-1:0] EDGE_BOTTOM = 2'd2;
	localparam logic [EDGE_W-1:0] EDGE_LEFT   = 2'd3;

	// one classified cell waiting for segment generation
	typedef struct packed {
		logic [ROW_W-1:0]             row;
		logic [ROW_W-1:0]             col;
		logic [3:0][BIAS_W-1:0]       bias;
		corner_t                      sa;
		corner_t                      sb;
		corner_t                      ea;
		corner_t                      eb;
		logic                         saddle;
	} cell_t;

	// endpoint side data that travels alongside the divider
	typedef struct packed {
		logic [BASE_W-1:0] base_row;
		logic [BASE_W-1:0] base_col;
		logic              horiz;
		logic              inc;
		logic              zero;
		logic [EDGE_W-1:0] edge_id;
		logic              last;
	} ep_meta_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_row_fx;
		logic [COORD_W-1:0] start_col_fx;
		logic [COORD_W-1:0] end_row_fx;
		logic [COORD_W-1:0] end_col_fx;
		logic [EDGE_W-1:0]  start_edge;
		logic [EDGE_W-1:0]  end_edge;
		logic               last_segment;
	} seg_t;

endpackage

### rtl/msc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_fifo - small register queue
// Flop based queue with push/full and pop/empty, oldest entry shown on rdata.
// ----------------------------------------------------------------------------
module msc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/msc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_front - cell classifier
// Thresholds the four corners, picks the segment corners and queues the cell.
// ----------------------------------------------------------------------------
module msc_front (
	input  logic                                push,
	input  logic                                cq_full,
	input  logic [msc_pkg::ROW_W-1:0]           cell_row,
	input  logic [msc_pkg::ROW_W-1:0]           cell_col,
	input  logic signed [msc_pkg::SAMPLE_W-1:0] sample_top_left,
	input  logic signed [msc_pkg::SAMPLE_W-1:0] sample_top_right,
	input  logic signed [msc_pkg::SAMPLE_W-1:0] sample_bottom_right,
	input  logic signed [msc_pkg::SAMPLE_W-1:0] sample_bottom_left,
	input  logic signed [msc_pkg::SAMPLE_W-1:0] thr,
	output logic                                cq_push,
	output msc_pkg::cell_t                      cq_data
);

	logic signed [msc_pkg::SAMPLE_W-1:0] smp [4];
	logic signed [msc_pkg::SAMPLE_W:0]   diff [4];
	logic [3:0]                          above;
	logic [2:0]                          n_above;
	logic                                odd_state;
	logic                                saddle;
	logic                                in_grid;
	logic                                keep;
	msc_pkg::corner_t                    c_odd;
	msc_pkg::corner_t                    c_adj;

	assign smp[0] = sample_top_left;
	assign smp[1] = sample_top_right;
	assign smp[2] = sample_bottom_right;
	assign smp[3] = sample_bottom_left;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			diff[k]  = {smp[k][msc_pkg::SAMPLE_W-1], smp[k]} - {thr[msc_pkg::SAMPLE_W-1], thr};
			above[k] = smp[k] > thr;
		end
	end

	assign n_above   = {2'b0, above[0]} + {2'b0, above[1]} + {2'b0, above[2]}
		+ {2'b0, above[3]};
	assign odd_state = (n_above == 3'd1);
	assign saddle    = (n_above == 3'd2) && (above[1] != above[2]) && (above[2] != above[3]);

	// first corner that is alone in its state, and first corner matching its neighbor
	always_comb begin
		c_odd = msc_pkg::CORNER_TL;
		c_adj = msc_pkg::CORNER_TL;
		for (int k = 3; k >= 0; k--) begin
			if (above[k] == odd_state) begin
				c_odd = 2'(k);
			end
			if (above[k] == above[2'(k + 1)]) begin
				c_adj = 2'(k);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cq_data.bias[k] = (diff[k] < 0) ? msc_pkg::BIAS_W'(-diff[k])
				: msc_pkg::BIAS_W'(diff[k]);
		end
		cq_data.row    = cell_row;
		cq_data.col    = cell_col;
		cq_data.saddle = saddle;
		cq_data.sa     = msc_pkg::CORNER_TL;
		cq_data.sb     = msc_pkg::CORNER_TL;
		cq_data.ea     = msc_pkg::CORNER_TL;
		cq_data.eb     = msc_pkg::CORNER_TL;
		case (n_above)
			3'd1, 3'd3: begin
				cq_data.sa = c_odd;
				cq_data.sb = c_odd + 2'd1;
				cq_data.ea = c_odd;
				cq_data.eb = c_odd + 2'd3;
			end
			3'd2: begin
				if (saddle) begin
					cq_data.sa = msc_pkg::CORNER_TL;
					cq_data.sb = msc_pkg::CORNER_TR;
					cq_data.ea = msc_pkg::CORNER_TR;
					cq_data.eb = msc_pkg::CORNER_BR;
				end else begin
					cq_data.sa = c_adj;
					cq_data.sb = c_adj + 2'd3;
					cq_data.ea = c_adj + 2'd2;
					cq_data.eb = c_adj + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_grid = ((32'(cell_row) + 32'd1) < 32'(msc_pkg::GRID_DIM))
		&& ((32'(cell_col) + 32'd1) < 32'(msc_pkg::GRID_DIM));
	assign keep    = in_grid && (n_above != 3'd0) && (n_above != 3'd4);
	assign cq_push = push && !cq_full && keep;

endmodule

### rtl/msc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_div - pipelined restoring divider
// Computes bias * 2^FRAC_BITS / sum for bias <= sum, one quotient bit a stage.
// ----------------------------------------------------------------------------
module msc_div #(
	parameter int FRAC_BITS = msc_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [msc_pkg::BIAS_W-1:0]  in_num,
	input  logic [msc_pkg::SUM_W-1:0]   in_den,
	input  msc_pkg::ep_meta_t           in_meta,
	output logic                        out_valid,
	output logic [FRAC_BITS:0]          out_quo,
	output logic                        out_rem_nz,
	output msc_pkg::ep_meta_t           out_meta
);

	localparam int NSTG  = FRAC_BITS + 1;
	localparam int REM_W = msc_pkg::SUM_W + 1;

	logic                        vld_s  [NSTG+1];
	logic [REM_W-1:0]            rem_s  [NSTG+1];
	logic [msc_pkg::SUM_W-1:0]   den_s  [NSTG+1];
	logic [FRAC_BITS:0]          quo_s  [NSTG+1];
	msc_pkg::ep_meta_t           meta_s [NSTG+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= REM_W'(in_num);
		den_s[0]  <= in_den;
		quo_s[0]  <= '0;
		meta_s[0] <= in_meta;
	end

	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		logic [REM_W-1:0] trial;
		logic [REM_W-1:0] sub;
		logic             ge;

		// the first step decides the integer bit, later steps shift in zeros
		if (k == 0) begin : g_first
			assign trial = rem_s[k];
		end else begin : g_next
			assign trial = {rem_s[k][REM_W-2:0], 1'b0};
		end

		assign sub = trial - {1'b0, den_s[k]};
		assign ge  = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? sub : trial;
			den_s[k+1]  <= den_s[k];
			quo_s[k+1]  <= {quo_s[k][FRAC_BITS-1:0], ge};
			meta_s[k+1] <= meta_s[k];
		end
	end

	assign out_valid  = vld_s[NSTG];
	assign out_quo    = quo_s[NSTG];
	assign out_rem_nz = (rem_s[NSTG] != '0);
	assign out_meta   = meta_s[NSTG];

endmodule

### rtl/msc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_back - segment generator
// One segment per cycle from the cell queue on credit, both ends interpolated.
// ----------------------------------------------------------------------------
module msc_back #(
	parameter int FRAC_BITS = msc_pkg::FRAC_BITS_DEF,
	parameter int OUT_DEPTH = msc_pkg::FRAC_BITS_DEF + 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cq_empty,
	input  msc_pkg::cell_t cq_data,
	output logic           cq_pop,
	input  logic           out_pop_done,
	output logic           out_push,
	output msc_pkg::seg_t  out_data
);

	localparam int CRD_W = $clog2(OUT_DEPTH + 1);
	localparam int FX_W  = msc_pkg::BASE_W + FRAC_BITS + 1;

	logic                      phase_q;
	logic [CRD_W-1:0]          credit_q;
	logic                      can_issue;
	logic                      last_seg;
	msc_pkg::corner_t          sa;
	msc_pkg::corner_t          sb;
	msc_pkg::corner_t          ea;
	msc_pkg::corner_t          eb;
	logic [msc_pkg::SUM_W-1:0] s_den;
	logic [msc_pkg::SUM_W-1:0] e_den;
	msc_pkg::ep_meta_t         s_meta_in;
	msc_pkg::ep_meta_t         e_meta_in;
	logic                      s_vld;
	logic                      e_vld;
	logic [FRAC_BITS:0]        s_quo;
	logic [FRAC_BITS:0]        e_quo;
	logic                      s_rnz;
	logic                      e_rnz;
	msc_pkg::ep_meta_t         s_meta;
	msc_pkg::ep_meta_t         e_meta;

	function automatic msc_pkg::ep_meta_t make_meta(
		input logic [msc_pkg::ROW_W-1:0] row,
		input logic [msc_pkg::ROW_W-1:0] col,
		input msc_pkg::corner_t          a,
		input msc_pkg::corner_t          b,
		input logic                      zero,
		input logic                      last
	);
		msc_pkg::ep_meta_t m;
		m.base_row = msc_pkg::BASE_W'(row)
			+ msc_pkg::BASE_W'((a == msc_pkg::CORNER_BR) || (a == msc_pkg::CORNER_BL));
		m.base_col = msc_pkg::BASE_W'(col)
			+ msc_pkg::BASE_W'((a == msc_pkg::CORNER_TR) || (a == msc_pkg::CORNER_BR));
		m.edge_id  = (b == a + 2'd1) ? a : b;
		m.horiz    = (m.edge_id == msc_pkg::EDGE_TOP) || (m.edge_id == msc_pkg::EDGE_BOTTOM);
		// direction of travel from corner a toward corner b on the varying axis
		m.inc      = m.horiz ? ((b == msc_pkg::CORNER_TR) || (b == msc_pkg::CORNER_BR))
			: ((b == msc_pkg::CORNER_BR) || (b == msc_pkg::CORNER_BL));
		m.zero     = zero;
		m.last     = last;
		return m;
	endfunction

	function automatic logic [msc_pkg::COORD_W-1:0] axis_fx(
		input logic [msc_pkg::BASE_W-1:0] base,
		input logic                       vary,
		input logic                       inc,
		input logic                       zero,
		input logic [FRAC_BITS:0]         quo,
		input logic                       rnz
	);
		logic [FX_W-1:0] b_fx;
		logic [FX_W-1:0] up;
		logic [FX_W-1:0] dn;
		logic [FX_W-1:0] v;
		b_fx = FX_W'(base) << FRAC_BITS;
		up   = zero ? '0 : FX_W'(quo);
		// going down the floor of the quotient becomes a ceiling
		dn   = zero ? '0 : FX_W'(quo) + FX_W'(rnz);
		if (!vary) begin
			v = b_fx;
		end else if (inc) begin
			v = b_fx + up;
		end else begin
			v = b_fx - dn;
		end
		return (32'(v) > 32'(msc_pkg::COORD_MAX)) ? msc_pkg::COORD_MAX
			: msc_pkg::COORD_W'(v);
	endfunction

	assign last_seg  = !cq_data.saddle || phase_q;
	assign can_issue = !cq_empty && (credit_q < CRD_W'(OUT_DEPTH));
	assign cq_pop    = can_issue && last_seg;

	always_comb begin
		if (phase_q) begin
			sa = msc_pkg::CORNER_BR;
			sb = msc_pkg::CORNER_BL;
			ea = msc_pkg::CORNER_BL;
			eb = msc_pkg::CORNER_TL;
		end else begin
			sa = cq_data.sa;
			sb = cq_data.sb;
			ea = cq_data.ea;
			eb = cq_data.eb;
		end
	end

	assign s_den = msc_pkg::SUM_W'(cq_data.bias[sa]) + msc_pkg::SUM_W'(cq_data.bias[sb]);
	assign e_den = msc_pkg::SUM_W'(cq_data.bias[ea]) + msc_pkg::SUM_W'(cq_data.bias[eb]);

	assign s_meta_in = make_meta(cq_data.row, cq_data.col, sa, sb, s_den == '0, last_seg);
	assign e_meta_in = make_meta(cq_data.row, cq_data.col, ea, eb, e_den == '0, last_seg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			credit_q <= '0;
		end else begin
			if (can_issue) begin
				phase_q <= cq_data.saddle && !phase_q;
			end
			// credits cover every segment in the dividers and in the result queue
			case ({can_issue, out_pop_done})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	msc_div #(.FRAC_BITS(FRAC_BITS)) u_div_start (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (can_issue),
		.in_num     (cq_data.bias[sa]),
		.in_den     (s_den),
		.in_meta    (s_meta_in),
		.out_valid  (s_vld),
		.out_quo    (s_quo),
		.out_rem_nz (s_rnz),
		.out_meta   (s_meta)
	);

	msc_div #(.FRAC_BITS(FRAC_BITS)) u_div_end (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (can_issue),
		.in_num     (cq_data.bias[ea]),
		.in_den     (e_den),
		.in_meta    (e_meta_in),
		.out_valid  (e_vld),
		.out_quo    (e_quo),
		.out_rem_nz (e_rnz),
		.out_meta   (e_meta)
	);

	assign out_push = s_vld && e_vld;

	always_comb begin
		out_data.start_row_fx = axis_fx(s_meta.base_row, !s_meta.horiz, s_meta.inc,
			s_meta.zero, s_quo, s_rnz);
		out_data.start_col_fx = axis_fx(s_meta.base_col, s_meta.horiz, s_meta.inc,
			s_meta.zero, s_quo, s_rnz);
		out_data.end_row_fx   = axis_fx(e_meta.base_row, !e_meta.horiz, e_meta.inc,
			e_meta.zero, e_quo, e_rnz);
		out_data.end_col_fx   = axis_fx(e_meta.base_col, e_meta.horiz, e_meta.inc,
			e_meta.zero, e_quo, e_rnz);
		out_data.start_edge   = s_meta.edge_id;
		out_data.end_edge     = e_meta.edge_id;
		out_data.last_segment = s_meta.last && e_meta.last;
	end

endmodule

### rtl/marching_squares_cell_segments_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marching_squares_cell_segments_unit - marching squares segment generator
// Path: an accepted cell goes through the cell queue and the bit-per-stage divider
//   into the result queue before its first segment shows.
// Throughput: one segment per cycle while a cell waits and credit is free, so
//   one plain cell per cycle; the single issue slot into the dividers sets it.
// Reset: arst_n clears the queues, the divider valids and the threshold to 0.
// ----------------------------------------------------------------------------
module marching_squares_cell_segments_unit #(
	parameter int FRAC_BITS = msc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic signed [msc_pkg::SAMPLE_W-1:0] cfg_wr_data,
	input  logic                                push,
	output logic                                full,
	input  logic [msc_pkg::ROW_W-1:0]           cell_row,
	input  logic [msc_pkg::ROW_W-1:0]           cell_col,
	input  logic signed [msc_pkg::SAMPLE_W-1:0] sample_top_left,
	input  logic signed [msc_pkg::SAMPLE_W-1:0] sample_top_right,
	input  logic signed [msc_pkg::SAMPLE_W-1:0] sample_bottom_right,
	input  logic signed [msc_pkg::SAMPLE_W-1:0] sample_bottom_left,
	output logic                                empty,
	input  logic                                pop,
	output logic [msc_pkg::COORD_W-1:0]         start_row_fx,
	output logic [msc_pkg::COORD_W-1:0]         start_col_fx,
	output logic [msc_pkg::COORD_W-1:0]         end_row_fx,
	output logic [msc_pkg::COORD_W-1:0]         end_col_fx,
	output logic [msc_pkg::EDGE_W-1:0]          start_edge,
	output logic [msc_pkg::EDGE_W-1:0]          end_edge,
	output logic                                last_segment
);

	localparam int OUT_DEPTH = FRAC_BITS + 4;
	localparam int CELL_W    = $bits(msc_pkg::cell_t);
	localparam int SEG_W     = $bits(msc_pkg::seg_t);

	logic signed [msc_pkg::SAMPLE_W-1:0] thr_q;
	logic                                cq_push;
	logic                                cq_empty;
	logic                                cq_pop;
	msc_pkg::cell_t                      cq_wdata;
	logic [CELL_W-1:0]                   cq_rdata;
	logic                                out_push;
	logic                                out_full;
	msc_pkg::seg_t                       out_wdata;
	logic [SEG_W-1:0]                    out_rdata;
	msc_pkg::seg_t                       out_seg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	msc_front u_front (
		.push                (push),
		.cq_full             (full),
		.cell_row            (cell_row),
		.cell_col            (cell_col),
		.sample_top_left     (sample_top_left),
		.sample_top_right    (sample_top_right),
		.sample_bottom_right (sample_bottom_right),
		.sample_bottom_left  (sample_bottom_left),
		.thr                 (thr_q),
		.cq_push             (cq_push),
		.cq_data             (cq_wdata)
	);

	msc_fifo #(.WIDTH(CELL_W), .DEPTH(msc_pkg::CQ_DEPTH)) u_cell_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.wdata  (cq_wdata),
		.full   (full),
		.pop    (cq_pop),
		.rdata  (cq_rdata),
		.empty  (cq_empty)
	);

	msc_back #(.FRAC_BITS(FRAC_BITS), .OUT_DEPTH(OUT_DEPTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cq_empty     (cq_empty),
		.cq_data      (msc_pkg::cell_t'(cq_rdata)),
		.cq_pop       (cq_pop),
		.out_pop_done (pop && !empty),
		.out_push     (out_push),
		.out_data     (out_wdata)
	);

	msc_fifo #(.WIDTH(SEG_W), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign out_seg      = msc_pkg::seg_t'(out_rdata);
	assign start_row_fx = out_seg.start_row_fx;
	assign start_col_fx = out_seg.start_col_fx;
	assign end_row_fx   = out_seg.end_row_fx;
	assign end_col_fx   = out_seg.end_col_fx;
	assign start_edge   = out_seg.start_edge;
	assign end_edge     = out_seg.end_edge;
	assign last_segment = out_seg.last_segment;

	// credit accounting must keep the result queue from overflowing
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_push && out_full))
		else $error("segment written into a full result queue");

	a_cq_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(cq_pop && cq_empty))
		else $error("cell queue popped while empty");

	// only the saddle gives a non-final segment, and it runs top to right
	a_saddle_first: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && !out_wdata.last_segment) |->
		(out_wdata.start_edge == msc_pkg::EDGE_TOP) && (out_wdata.end_edge == msc_pkg::EDGE_RIGHT))
		else $error("non-final segment is not the saddle top-right segment");

	a_edges_differ: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (out_wdata.start_edge != out_wdata.end_edge))
		else $error("segment starts and ends on the same edge");

endmodule
